/* rtl/assert_macros.svh */
// Assertion macros used by the checker of this project.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MSID_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication: when pre holds, post must hold at the next clock edge.
`define MSID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/msid_pkg.sv */
// Package for the MIPS subset decoder: result codes, result record and decode function.
// No dependencies; used by the decoder top level and its checker.
package msid_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned OutDataWidth = 72;
  localparam int unsigned OutUserWidth = 4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_BADREG  = 2'd2;

  // Instruction kinds.
  localparam logic [3:0] K_ADD   = 4'd0;
  localparam logic [3:0] K_ADDU  = 4'd1;
  localparam logic [3:0] K_SUB   = 4'd2;
  localparam logic [3:0] K_SUBU  = 4'd3;
  localparam logic [3:0] K_ADDI  = 4'd4;
  localparam logic [3:0] K_ADDIU = 4'd5;
  localparam logic [3:0] K_SLL   = 4'd6;
  localparam logic [3:0] K_SRL   = 4'd7;
  localparam logic [3:0] K_BEQ   = 4'd8;
  localparam logic [3:0] K_BNE   = 4'd9;
  localparam logic [3:0] K_J     = 4'd10;
  localparam logic [3:0] K_JR    = 4'd11;

  // Instruction formats.
  localparam logic [1:0] FMT_R = 2'd0;
  localparam logic [1:0] FMT_I = 2'd1;
  localparam logic [1:0] FMT_J = 2'd2;

  // Pseudo-instruction flags.
  localparam logic [1:0] PS_NONE  = 2'd0;
  localparam logic [1:0] PS_NOP   = 2'd1;
  localparam logic [1:0] PS_CLEAR = 2'd2;
  localparam logic [1:0] PS_MOVE  = 2'd3;

  // Opcodes and function codes.
  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_BEQ     = 6'd4;
  localparam logic [5:0] OPC_BNE     = 6'd5;
  localparam logic [5:0] OPC_ADDI    = 6'd8;
  localparam logic [5:0] OPC_ADDIU   = 6'd9;
  localparam logic [5:0] FN_SLL      = 6'd0;
  localparam logic [5:0] FN_SRL      = 6'd2;
  localparam logic [5:0] FN_JR       = 6'd8;
  localparam logic [5:0] FN_ADD      = 6'd32;
  localparam logic [5:0] FN_ADDU     = 6'd33;
  localparam logic [5:0] FN_SUB      = 6'd34;
  localparam logic [5:0] FN_SUBU     = 6'd35;

  // Which immediate-like field an instruction carries.
  localparam logic [1:0] IMM_NONE  = 2'd0;
  localparam logic [1:0] IMM_16    = 2'd1;
  localparam logic [1:0] IMM_SHAMT = 2'd2;
  localparam logic [1:0] IMM_JUMP  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  kind;
    logic [1:0]  fmt;
    logic [1:0]  pseudo;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [15:0] immediate;
    logic [27:0] jump_target;
    logic [2:0]  regs_used;
  } msid_res_t;

  // Allowed registers: zero, at, t0..t7, t8, t9.
  function automatic logic msid_reg_ok(logic [4:0] r);
    return (r == 5'd0) || (r == 5'd1) || (r[4:3] == 2'b01) ||
           (r == 5'd24) || (r == 5'd25);
  endfunction

  function automatic msid_res_t msid_decode(logic [InstrWidth-1:0] w);
    msid_res_t   res;
    logic        match;
    logic [1:0]  imm_sel;
    logic        bad_reg;
    logic [5:0]  opc;
    logic [5:0]  fn;
    res     = '0;
    match   = 1'b1;
    imm_sel = IMM_NONE;
    opc     = w[31:26];
    fn      = w[5:0];

    unique case (opc)
      OPC_SPECIAL: begin
        res.fmt = FMT_R;
        res.regs_used = 3'b111;
        unique case (fn)
          FN_ADD:  res.kind = K_ADD;
          FN_ADDU: res.kind = K_ADDU;
          FN_SUB:  res.kind = K_SUB;
          FN_SUBU: res.kind = K_SUBU;
          FN_SLL: begin
            res.kind = K_SLL;
            res.regs_used = 3'b110;
            imm_sel = IMM_SHAMT;
          end
          FN_SRL: begin
            res.kind = K_SRL;
            res.regs_used = 3'b110;
            imm_sel = IMM_SHAMT;
          end
          FN_JR: begin
            res.kind = K_JR;
            res.regs_used = 3'b001;
          end
          default: match = 1'b0;
        endcase
      end
      OPC_ADDI, OPC_ADDIU, OPC_BEQ, OPC_BNE: begin
        res.fmt = FMT_I;
        res.regs_used = 3'b011;
        imm_sel = IMM_16;
        unique case (opc)
          OPC_ADDI:  res.kind = K_ADDI;
          OPC_ADDIU: res.kind = K_ADDIU;
          OPC_BEQ:   res.kind = K_BEQ;
          default:   res.kind = K_BNE;
        endcase
      end
      OPC_J: begin
        res.kind = K_J;
        res.fmt = FMT_J;
        imm_sel = IMM_JUMP;
      end
      default: match = 1'b0;
    endcase

    if (!match) begin
      res = '0;
      res.status = ST_UNKNOWN;
    end else begin
      unique case (imm_sel)
        IMM_16:    res.immediate = w[15:0];
        IMM_SHAMT: res.immediate = {11'd0, w[10:6]};
        IMM_JUMP:  res.jump_target = {w[25:0], 2'b00};
        default:   res.immediate = '0;
      endcase
      if (res.regs_used[0]) res.src_reg = w[25:21];
      if (res.regs_used[1]) res.tgt_reg = w[20:16];
      if (res.regs_used[2]) res.dst_reg = w[15:11];

      bad_reg = (res.regs_used[0] && !msid_reg_ok(res.src_reg)) ||
                (res.regs_used[1] && !msid_reg_ok(res.tgt_reg)) ||
                (res.regs_used[2] && !msid_reg_ok(res.dst_reg));

      // Priority: register check, then nop, clear and move.
      if (bad_reg) begin
        res.status = ST_BADREG;
      end else if (res.kind == K_SLL && res.immediate == '0 &&
                   res.dst_reg == '0 && res.tgt_reg == '0) begin
        res.pseudo = PS_NOP;
      end else if (res.kind == K_ADDU && res.src_reg == '0 && res.tgt_reg == '0) begin
        res.pseudo = PS_CLEAR;
      end else if (res.kind == K_ADDIU && res.immediate == '0) begin
        res.pseudo = PS_MOVE;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/mips_subset_instruction_decoder_unit.sv */
// Top level of the MIPS subset instruction decoder: input register, decode, result register.
// Depends on msid_pkg for the result record and the decode function.
//
// Usage:
//   The input channel (in_tvalid, in_tready, in_tdata) carries one 32-bit
//   instruction word per item. The result channel (out_tvalid, out_tready,
//   out_tdata, out_tuser) returns exactly one decoded result item per input
//   item, in order. out_tuser carries the instruction kind; out_tdata packs
//   the status, format, pseudo flag, register numbers, immediate, jump
//   target and the register-use mask.
//   A word accepted at a clock edge sits in the input register, is decoded
//   by one level of combinational logic and is loaded into the result
//   register once that register is empty or being read.
//   Throughput is one item per cycle while the receiver takes every result;
//   in_tready and the result register's advance condition set this figure.
//   Reset (synchronous, rst_n low) empties both registers; no result is
//   shown until a new word is accepted.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more word; with both full, in_tready drops
//   until the receiver takes the waiting result.
//   Unknown encodings give status 1 with all other fields zero; a register
//   outside the allowed set gives status 2 with the decoded fields kept.
module mips_subset_instruction_decoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [msid_pkg::InstrWidth-1:0]     in_tdata,   // [31:0] instr_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [3:2] format, [5:4] pseudo, [10:6] src_reg, [15:11] tgt_reg,
  // [20:16] dst_reg, [36:21] immediate, [64:37] jump_target, [67:65] regs_used,
  // [71:68] zero
  output logic [msid_pkg::OutDataWidth-1:0]   out_tdata,
  output logic [msid_pkg::OutUserWidth-1:0]   out_tuser   // [3:0] kind
);
  import msid_pkg::*;

  logic                  in_vld_r;
  logic                  in_vld_nxt;
  logic [InstrWidth-1:0] in_word_r;
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  msid_res_t             res_r;
  msid_res_t             res_nxt;
  logic                  advance;

  // The result register can take a new item when it is empty or being read.
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;

  assign in_vld_nxt  = in_tready ? in_tvalid : in_vld_r;
  assign out_vld_nxt = advance ? in_vld_r : out_vld_r;
  assign res_nxt     = msid_decode(in_word_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_word_r <= in_tdata;
    end
    if (advance && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {4'd0, res_r.regs_used, res_r.jump_target, res_r.immediate,
                       res_r.dst_reg, res_r.tgt_reg, res_r.src_reg, res_r.pseudo,
                       res_r.fmt, res_r.status};

endmodule

/* rtl/msid_checker.sv */
// Port-level checker for the MIPS subset decoder, bound to its top level.
// Depends on msid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msid_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [msid_pkg::InstrWidth-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [msid_pkg::OutDataWidth-1:0] out_tdata,
  input logic [msid_pkg::OutUserWidth-1:0] out_tuser
);
  import msid_pkg::*;

  logic unknown;
  logic [1:0] pseudo;
  assign unknown = out_tdata[1:0] == ST_UNKNOWN;
  assign pseudo  = out_tdata[5:4];

  // A stalled result item must hold.
  `MSID_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Unknown encodings carry nothing but their status.
  `MSID_ASSERT_ALWAYS(a_unknown_zero, !out_tvalid || !unknown || (out_tdata[71:2] == '0 && out_tuser == '0), "unknown encoding with nonzero fields")

  // A pseudo flag is only given on an item that passed the register check.
  `MSID_ASSERT_ALWAYS(a_pseudo_ok, !out_tvalid || pseudo == PS_NONE || out_tdata[1:0] == ST_OK, "pseudo flag on a failed item")

  // A jump carries the J format and no register fields.
  `MSID_ASSERT_ALWAYS(a_jump_fmt, !out_tvalid || unknown || out_tuser != K_J || (out_tdata[3:2] == FMT_J && out_tdata[67:65] == 3'b000), "jump decoded with wrong format")

  // With the result register empty, an accepted word leaves a valid result once it has passed both registers.
  `MSID_ASSERT_NEXT(a_latency, in_tvalid && in_tready && !out_tvalid, ##1 out_tvalid, "result did not appear")

endmodule

bind mips_subset_instruction_decoder_unit msid_checker u_msid_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the MIPS subset instruction decoder unit.
// Depends on msid_pkg for the code constants and on the decoder top level;
// nothing else is read.
`timescale 1ns / 1ps

module testbench;
  import msid_pkg::*;

  // Cycles without any handshake on either side before the run is called hung.
  // This is well above the long receiver hold-off below.
  localparam int IdleLimit = 3000;
  // Receiver hold-off that backs the block up and stalls its input side.
  localparam int LongHold = 400;
  // Number of random instruction words after the directed list.
  localparam int RandomWords = 2000;

  // One decoded instruction, laid out field by field as the block reports it.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  kind;
    logic [1:0]  fmt;
    logic [1:0]  pseudo;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [15:0] immediate;
    logic [27:0] jump_target;
    logic [2:0]  regs_used;
  } decoded_t;

  // Every input of the block starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [3:0]  out_tuser;

  // Instruction words waiting to be offered, and decodes waiting to come back.
  logic [31:0] pending_words[$];
  decoded_t    awaited_decodes[$];

  int mismatches = 0;
  int words_sent = 0;
  int decodes_seen = 0;
  int idle_cycles = 0;
  int status_tally[3] = '{0, 0, 0};
  int pseudo_tally[4] = '{0, 0, 0, 0};

  // Sender burst state.
  int burst_left = 1;
  int gap_left = 0;

  // Receiver stall state: a mode picked anew every segment, plus one long hold.
  int  ready_mode = 0;
  int  segment_left = 1;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  phase_cnt = 0;

  mips_subset_instruction_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Registers that the decoder accepts: zero, at, t0 through t7, t8 and t9.
  function automatic logic reg_in_set(input logic [4:0] r);
    return (r == 5'd0) || (r == 5'd1) || (r >= 5'd8 && r <= 5'd15) ||
           (r == 5'd24) || (r == 5'd25);
  endfunction

  // Works out the decode of one instruction word. First the opcode (and the
  // function code for the special opcode) selects the instruction; then the
  // instruction's format, register-use mask and immediate source follow
  // from the kind alone.
  function automatic decoded_t decode_instr(input logic [31:0] w);
    decoded_t   d;
    logic       known;
    logic       take_imm16;
    logic       take_shamt;
    logic       take_index;
    logic [5:0] opc;
    logic [5:0] fn;
    d = '0;
    known = 1'b1;
    take_imm16 = 1'b0;
    take_shamt = 1'b0;
    take_index = 1'b0;
    opc = w[31:26];
    fn = w[5:0];
    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_ADD:  d.kind = K_ADD;
          FN_ADDU: d.kind = K_ADDU;
          FN_SUB:  d.kind = K_SUB;
          FN_SUBU: d.kind = K_SUBU;
          FN_SLL:  d.kind = K_SLL;
          FN_SRL:  d.kind = K_SRL;
          FN_JR:   d.kind = K_JR;
          default: known = 1'b0;
        endcase
      end
      OPC_ADDI:  d.kind = K_ADDI;
      OPC_ADDIU: d.kind = K_ADDIU;
      OPC_BEQ:   d.kind = K_BEQ;
      OPC_BNE:   d.kind = K_BNE;
      OPC_J:     d.kind = K_J;
      default:   known = 1'b0;
    endcase

    // An unknown encoding reports nothing but its status.
    if (!known) begin
      d = '0;
      d.status = ST_UNKNOWN;
      return d;
    end

    case (d.kind)
      K_ADD, K_ADDU, K_SUB, K_SUBU: begin
        d.fmt = FMT_R;
        d.regs_used = 3'b111;
      end
      K_SLL, K_SRL: begin
        d.fmt = FMT_R;
        d.regs_used = 3'b110;
        take_shamt = 1'b1;
      end
      K_JR: begin
        d.fmt = FMT_R;
        d.regs_used = 3'b001;
      end
      K_J: begin
        d.fmt = FMT_J;
        d.regs_used = 3'b000;
        take_index = 1'b1;
      end
      default: begin
        d.fmt = FMT_I;
        d.regs_used = 3'b011;
        take_imm16 = 1'b1;
      end
    endcase

    if (take_imm16) d.immediate = w[15:0];
    if (take_shamt) d.immediate = 16'(w[10:6]);
    if (take_index) d.jump_target = {w[25:0], 2'b00};
    if (d.regs_used[0]) d.src_reg = w[25:21];
    if (d.regs_used[1]) d.tgt_reg = w[20:16];
    if (d.regs_used[2]) d.dst_reg = w[15:11];

    // A disallowed register wins over every pseudo-instruction; after that,
    // nop, clear and move are tried in that order.
    if ((d.regs_used[0] && !reg_in_set(d.src_reg)) ||
        (d.regs_used[1] && !reg_in_set(d.tgt_reg)) ||
        (d.regs_used[2] && !reg_in_set(d.dst_reg))) begin
      d.status = ST_BADREG;
    end else if (d.kind == K_SLL && d.immediate == 16'd0 && d.dst_reg == 5'd0 &&
                 d.tgt_reg == 5'd0) begin
      d.pseudo = PS_NOP;
    end else if (d.kind == K_ADDU && d.src_reg == 5'd0 && d.tgt_reg == 5'd0) begin
      d.pseudo = PS_CLEAR;
    end else if (d.kind == K_ADDIU && d.immediate == 16'd0) begin
      d.pseudo = PS_MOVE;
    end else begin
      d.pseudo = PS_NONE;
    end
    return d;
  endfunction

  // Encoders for the three instruction formats.
  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OPC_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(input logic [25:0] index);
    return {OPC_J, index};
  endfunction

  // Mostly an allowed register, now and then any register at all.
  function automatic logic [4:0] pick_reg();
    int idx;
    if ($urandom_range(0, 99) < 8) return 5'($urandom_range(0, 31));
    idx = $urandom_range(0, 11);
    if (idx < 2) return 5'(idx);
    if (idx < 10) return 5'(idx + 6);
    return 5'(idx + 14);
  endfunction

  // A well-formed word of the given kind with random content. Unused fields
  // keep random bits, and the pseudo-instruction patterns are favored.
  function automatic logic [31:0] build_word(input logic [3:0] kind);
    logic [31:0] w;
    int          roll;
    w = $urandom();
    if (kind != K_J) begin
      w[25:21] = pick_reg();
      w[20:16] = pick_reg();
      w[15:11] = pick_reg();
    end
    roll = $urandom_range(0, 5);
    if (roll == 0) w[15:0] = 16'h0000;
    if (roll == 1) w[15:0] = 16'hffff;
    case (kind)
      K_ADD:   w[5:0] = FN_ADD;
      K_ADDU:  w[5:0] = FN_ADDU;
      K_SUB:   w[5:0] = FN_SUB;
      K_SUBU:  w[5:0] = FN_SUBU;
      K_SLL:   w[5:0] = FN_SLL;
      K_SRL:   w[5:0] = FN_SRL;
      default: w[5:0] = FN_JR;
    endcase
    case (kind)
      K_ADDI:  w[31:26] = OPC_ADDI;
      K_ADDIU: w[31:26] = OPC_ADDIU;
      K_BEQ:   w[31:26] = OPC_BEQ;
      K_BNE:   w[31:26] = OPC_BNE;
      K_J:     w[31:26] = OPC_J;
      default: w[31:26] = OPC_SPECIAL;
    endcase
    // Steer toward nop and clear often enough to see them regularly.
    if (kind == K_SLL && $urandom_range(0, 3) == 0) w[20:6] = '0;
    if (kind == K_ADDU && $urandom_range(0, 3) == 0) w[25:16] = '0;
    return w;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: offers pending words in bursts separated by random gaps. A word
  // that is offered stays put until the handshake takes it, and the valid
  // line is assigned once per edge so a back-to-back item never glitches it.
  always @(posedge clk) begin : feed_proc
    logic        next_valid;
    logic [31:0] next_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      next_valid = in_tvalid;
      next_word = in_tdata;
      if (in_tvalid && in_tready) begin
        awaited_decodes.push_back(decode_instr(in_tdata));
        words_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          next_valid = 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Half of the bursts follow on with no gap at all.
            gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= next_valid;
      in_tdata <= next_word;
    end
  end

  // Receiver and checker: every accepted result item is unpacked and
  // compared with the oldest outstanding decode. The ready line follows a
  // mode picked anew per segment; once, after enough results, it is held
  // low for a long stretch so both registers of the block fill and the
  // input side stalls while the sender keeps offering.
  always @(posedge clk) begin : check_proc
    decoded_t want;
    decoded_t got;
    logic     next_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.fmt = out_tdata[3:2];
        got.pseudo = out_tdata[5:4];
        got.src_reg = out_tdata[10:6];
        got.tgt_reg = out_tdata[15:11];
        got.dst_reg = out_tdata[20:16];
        got.immediate = out_tdata[36:21];
        got.jump_target = out_tdata[64:37];
        got.regs_used = out_tdata[67:65];
        got.kind = out_tuser;
        if (awaited_decodes.size() == 0) begin
          $error("result item arrived with no instruction word outstanding");
          mismatches++;
        end else begin
          want = awaited_decodes.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("kind", 32'(want.kind), 32'(got.kind));
          report_field("format", 32'(want.fmt), 32'(got.fmt));
          report_field("pseudo", 32'(want.pseudo), 32'(got.pseudo));
          report_field("src_reg", 32'(want.src_reg), 32'(got.src_reg));
          report_field("tgt_reg", 32'(want.tgt_reg), 32'(got.tgt_reg));
          report_field("dst_reg", 32'(want.dst_reg), 32'(got.dst_reg));
          report_field("immediate", 32'(want.immediate), 32'(got.immediate));
          report_field("jump_target", 32'(want.jump_target), 32'(got.jump_target));
          report_field("regs_used", 32'(want.regs_used), 32'(got.regs_used));
          report_field("tdata padding", 32'd0, 32'(out_tdata[71:68]));
          status_tally[want.status]++;
          pseudo_tally[want.pseudo]++;
          decodes_seen++;
        end
      end

      phase_cnt++;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        next_ready = 1'b0;
      end else if (!hold_done && decodes_seen >= 500) begin
        hold_done = 1'b1;
        hold_left = LongHold;
        next_ready = 1'b0;
      end else begin
        segment_left = segment_left - 1;
        if (segment_left <= 0) begin
          ready_mode = $urandom_range(0, 3);
          segment_left = $urandom_range(20, 200);
        end
        case (ready_mode)
          0:       next_ready = 1'b1;
          1:       next_ready = ($urandom_range(0, 3) != 0);
          2:       next_ready = (phase_cnt % 3 == 0);
          default: next_ready = ($urandom_range(0, 1) != 0);
        endcase
      end
      out_tready <= next_ready;
    end
  end

  // Watchdog: a run with no handshake on either side for too long is hung.
  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus_proc
    int          roll;
    logic [31:0] w;

    // Directed words: extremes, every instruction, the pseudo-instructions,
    // a bad register in each position, and unknown opcodes and functions.
    pending_words.push_back(32'h0000_0000);                       // nop
    pending_words.push_back(32'hffff_ffff);                       // unknown opcode
    pending_words.push_back(enc_r(5'd8, 5'd9, 5'd10, 5'd0, FN_ADD));
    pending_words.push_back(enc_r(5'd11, 5'd12, 5'd13, 5'd7, FN_ADDU));
    pending_words.push_back(enc_r(5'd14, 5'd15, 5'd24, 5'd0, FN_SUB));
    pending_words.push_back(enc_r(5'd25, 5'd1, 5'd0, 5'd31, FN_SUBU));
    pending_words.push_back(enc_i(OPC_ADDI, 5'd8, 5'd9, 16'hffff));
    pending_words.push_back(enc_i(OPC_ADDIU, 5'd10, 5'd11, 16'h8000));
    pending_words.push_back(enc_r(5'd0, 5'd12, 5'd13, 5'd31, FN_SLL));
    pending_words.push_back(enc_r(5'd31, 5'd14, 5'd15, 5'd5, FN_SRL));
    pending_words.push_back(enc_i(OPC_BEQ, 5'd24, 5'd25, 16'h0001));
    pending_words.push_back(enc_i(OPC_BNE, 5'd1, 5'd0, 16'h7fff));
    pending_words.push_back(enc_j(26'h3ff_ffff));                 // widest jump index
    pending_words.push_back(enc_j(26'h000_0000));
    pending_words.push_back(enc_r(5'd25, 5'd31, 5'd31, 5'd31, FN_JR));
    pending_words.push_back(enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_SLL)); // nop, rs ignored
    pending_words.push_back(enc_r(5'd0, 5'd0, 5'd25, 5'd3, FN_ADDU)); // clear
    pending_words.push_back(enc_i(OPC_ADDIU, 5'd9, 5'd8, 16'h0000));  // move
    pending_words.push_back(enc_r(5'd2, 5'd8, 5'd9, 5'd0, FN_ADD));   // bad rs
    pending_words.push_back(enc_r(5'd8, 5'd16, 5'd9, 5'd0, FN_SUB));  // bad rt
    pending_words.push_back(enc_r(5'd8, 5'd9, 5'd31, 5'd0, FN_ADDU)); // bad rd
    pending_words.push_back(enc_r(5'd7, 5'd0, 5'd0, 5'd0, FN_JR));    // bad rs in jr
    pending_words.push_back(enc_i(OPC_ADDIU, 5'd2, 5'd8, 16'h0000));  // bad reg beats move
    pending_words.push_back(enc_r(5'd0, 5'd0, 5'd0, 5'd0, 6'd1));     // unknown function
    pending_words.push_back({6'd3, 26'h3ff_ffff});                    // unknown opcode

    // Random words: mostly well-formed instructions with random content,
    // some special-opcode words with any function code, some pure noise.
    repeat (RandomWords) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        w = build_word(4'($urandom_range(0, 11)));
      end else if (roll < 88) begin
        w = $urandom();
        w[31:26] = OPC_SPECIAL;
      end else begin
        w = $urandom();
      end
      pending_words.push_back(w);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word is taken and every decode has come back, then
    // keep clocking to catch any stray result item.
    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words and checked %0d decodes: %0d ok, %0d unknown,",
             words_sent, decodes_seen, status_tally[ST_OK], status_tally[ST_UNKNOWN]);
    $display("%0d with a disallowed register; pseudo-instructions: %0d nop, %0d clear, %0d move.",
             status_tally[ST_BADREG], pseudo_tally[PS_NOP], pseudo_tally[PS_CLEAR],
             pseudo_tally[PS_MOVE]);
    if (mismatches == 0 && awaited_decodes.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
